>>> rtl/grg_pkg.sv
// ----------------------------------------------------------------------------
// grg_pkg: gain ramp generator definitions
// Codes, fixed-point constants and reciprocal tables for the series divisors.
// ----------------------------------------------------------------------------
`default_nettype none

package grg_pkg;

  localparam int GAIN_FRAC_BITS = 28;
  localparam int EXP_BIAS       = GAIN_FRAC_BITS - 30;

  localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
  localparam logic [31:0] LN2_Q30        = 32'd744261118;
  localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;
  localparam logic [31:0] DB_TO_LOG2_Q32 = 32'd2786635;
  localparam logic [31:0] GAIN_MAX       = 32'hFFFF_FFFF;
  localparam logic [31:0] UNITY_GAIN     = 32'h1000_0000;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_RAMP = 2'd1,
    CMD_JUMP = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CURVE_HOLD = 2'd0,
    CURVE_IN   = 2'd1,
    CURVE_OUT  = 2'd2,
    CURVE_DB   = 2'd3
  } curve_t;

  // floor(a / d) = (a * mult) >> shift for any 32-bit a
  typedef struct packed {
    logic [32:0] mult;
    logic [5:0]  shift;
  } recip_t;

  // divisor k of the exp series
  function automatic recip_t exp_recip(input logic [3:0] k);
    recip_t r;
    case (k)
      4'd2:    r = '{mult: 33'd4294967296, shift: 6'd33};
      4'd3:    r = '{mult: 33'd5726623062, shift: 6'd34};
      4'd4:    r = '{mult: 33'd4294967296, shift: 6'd34};
      4'd5:    r = '{mult: 33'd6871947674, shift: 6'd35};
      4'd6:    r = '{mult: 33'd5726623062, shift: 6'd35};
      4'd7:    r = '{mult: 33'd4908534053, shift: 6'd35};
      4'd8:    r = '{mult: 33'd4294967296, shift: 6'd35};
      4'd9:    r = '{mult: 33'd7635497416, shift: 6'd36};
      4'd10:   r = '{mult: 33'd6871947674, shift: 6'd36};
      4'd11:   r = '{mult: 33'd6247225158, shift: 6'd36};
      4'd12:   r = '{mult: 33'd5726623062, shift: 6'd36};
      4'd13:   r = '{mult: 33'd5286113596, shift: 6'd36};
      default: r = '{mult: 33'd4294967296, shift: 6'd32};
    endcase
    return r;
  endfunction

  // divisor (2k)(2k+1) of the sine series
  function automatic recip_t sin_recip(input logic [3:0] k);
    recip_t r;
    case (k)
      4'd2:    r = '{mult: 33'd6871947674, shift: 6'd37};
      4'd3:    r = '{mult: 33'd6544712071, shift: 6'd38};
      4'd4:    r = '{mult: 33'd7635497416, shift: 6'd39};
      4'd5:    r = '{mult: 33'd4997780127, shift: 6'd39};
      4'd6:    r = '{mult: 33'd7048151461, shift: 6'd40};
      4'd7:    r = '{mult: 33'd5235769657, shift: 6'd40};
      4'd8:    r = '{mult: 33'd8084644322, shift: 6'd41};
      default: r = '{mult: 33'd5726623062, shift: 6'd35};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gain_ramp_generator_unit.sv
// ----------------------------------------------------------------------------
// gain_ramp_generator_unit
// Gain fade generator: dB jumps, equal-power and dB-domain ramps, one gain
// word per tick.
// ----------------------------------------------------------------------------
// One word is taken at a time and s_axis_tready stays low until it is done.
// A ramp command onto a dB curve also works out the two log2 values. The
// 24-step restoring divider and one registered 32x33 multiplier are reused
// for the exp, sine and log2 iterations. A result may wait on the master
// side while the next word is taken.
`default_nettype none

module gain_ramp_generator_unit
  import grg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] level_db, [16] mute, [40:17] ramp_frames, [47:41] zero
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] gain, [32] ramping, [39:33] zero
  output logic [39:0]      m_axis_tdata
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_LV_MUL, ST_LV_E, ST_EX_Y, ST_EX_Y2, ST_EX_T, ST_EX_D, ST_EX_R,
    ST_EX_OUT, ST_APPLY, ST_LG_INIT, ST_LG_SQ, ST_LG_UP, ST_TK_START, ST_TK_DIV,
    ST_TK_SEL, ST_SN_X, ST_SN_X2, ST_SN_R0, ST_SN_T, ST_SN_D, ST_SN_R, ST_SN_S,
    ST_SN_F, ST_SN_G, ST_DB_LO, ST_DB_HI, ST_DB_E, ST_EMIT
  } state_t;

  state_t      state;
  cmd_t        cmd_r;
  logic [15:0] db_r;
  logic [23:0] frames_r;
  logic [31:0] cur_gain, start_gain, target_gain, tg;
  logic [23:0] ramp_len, ramp_pos;
  curve_t      curve;
  logic [39:0] log_start, log_diff, e_reg;
  logic [31:0] hreg, xreg, rreg, dlo;
  logic [3:0]  kcnt;
  logic        ret_db, lg_phase;
  logic [31:0] lg_m, lg_frac;
  logic [4:0]  lg_b, icnt, div_cnt;
  logic [23:0] div_rem, div_q, prog;
  logic [24:0] sarg;
  logic [64:0] prod;
  logic [31:0] out_gain;
  logic        out_ramping;

  // shared multiplier
  logic [31:0] mul_a;
  logic [32:0] mul_b;

  recip_t      rcp;
  logic [31:0] quot;
  logic [15:0] dmag;
  logic [39:0] diff_mag, delta;
  logic [31:0] mm, s_clamp, lg_x, exp_v;
  logic [4:0]  msb;
  logic [8:0]  amt, amt_neg;
  logic [32:0] exp_v2;
  logic [24:0] rem2;
  logic [23:0] pos_inc;
  logic [7:0]  lg_hi;

  always_comb begin
    rcp = (state == ST_SN_D || state == ST_SN_R) ? sin_recip(kcnt) : exp_recip(kcnt);
    quot = 32'(prod >> rcp.shift);
    dmag = db_r[15] ? 16'(-db_r) : db_r;
    diff_mag = log_diff[39] ? 40'(-log_diff) : log_diff;
    delta = {prod[31:0], 8'b0} + {8'b0, dlo};
    mm = prod[61:30];
    s_clamp = (prod[63:30] > {2'b0, ONE_Q30}) ? ONE_Q30 : prod[61:30];
    rem2 = {div_rem, 1'b0};
    pos_inc = ramp_pos + 24'd1;
    lg_hi = {3'b000, lg_b} - 8'(GAIN_FRAC_BITS);

    lg_x = lg_phase ? target_gain : start_gain;
    if (lg_x == 32'd0) begin
      lg_x = 32'd1;
    end
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (lg_x[i]) msb = 5'(i);
    end

    amt = 9'({{1{e_reg[39]}}, e_reg[39:32]} + 9'(EXP_BIAS));
    amt_neg = 9'(-amt);
    exp_v2 = {rreg, 1'b0};
    if (!amt[8] && amt >= 9'd2) begin
      exp_v = GAIN_MAX;
    end else if (amt == 9'd1) begin
      exp_v = exp_v2[32] ? GAIN_MAX : exp_v2[31:0];
    end else if (amt == 9'd0) begin
      exp_v = rreg;
    end else if (amt_neg >= 9'd32) begin
      exp_v = 32'd0;
    end else begin
      exp_v = rreg >> amt_neg[4:0];
    end

    mul_a = 32'd0;
    mul_b = 33'd0;
    case (state)
      ST_LV_MUL: begin
        mul_a = {16'b0, dmag};
        mul_b = {1'b0, DB_TO_LOG2_Q32};
      end
      ST_EX_Y: begin
        mul_a = e_reg[31:0];
        mul_b = {1'b0, LN2_Q30};
      end
      ST_EX_T, ST_SN_T: begin
        mul_a = hreg;
        mul_b = {1'b0, rreg};
      end
      ST_EX_D, ST_SN_D: begin
        mul_a = prod[61:30];
        mul_b = rcp.mult;
      end
      ST_LG_SQ: begin
        mul_a = lg_m;
        mul_b = {1'b0, lg_m};
      end
      ST_SN_X: begin
        mul_a = {7'b0, sarg};
        mul_b = {1'b0, HALF_PI_Q30};
      end
      ST_SN_X2: begin
        mul_a = {1'b0, prod[54:24]};
        mul_b = {2'b0, prod[54:24]};
      end
      ST_SN_S: begin
        mul_a = xreg;
        mul_b = {1'b0, rreg};
      end
      ST_SN_F: begin
        mul_a = (curve == CURVE_IN) ? target_gain : start_gain;
        mul_b = {1'b0, s_clamp};
      end
      ST_DB_LO: begin
        mul_a = diff_mag[31:0];
        mul_b = {9'b0, prog};
      end
      ST_DB_HI: begin
        mul_a = {24'b0, diff_mag[39:32]};
        mul_b = {9'b0, prog};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 33'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {33'b0, mul_a} * {32'b0, mul_b};
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      cur_gain      <= UNITY_GAIN;
      start_gain    <= UNITY_GAIN;
      target_gain   <= UNITY_GAIN;
      ramp_len      <= 24'd0;
      ramp_pos      <= 24'd0;
      curve         <= CURVE_HOLD;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != ST_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_r    <= cmd_t'(s_axis_tuser);
            db_r     <= s_axis_tdata[15:0];
            frames_r <= s_axis_tdata[40:17];
            case (cmd_t'(s_axis_tuser))
              CMD_TICK: state <= ST_TK_START;
              CMD_RAMP, CMD_JUMP: begin
                if (s_axis_tdata[16]) begin
                  tg    <= 32'd0;
                  state <= ST_APPLY;
                end else begin
                  state <= ST_LV_MUL;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_LV_MUL: state <= ST_LV_E;
        ST_LV_E: begin
          e_reg  <= db_r[15] ? 40'(-prod[39:0]) : prod[39:0];
          ret_db <= 1'b0;
          state  <= ST_EX_Y;
        end
        ST_EX_Y: state <= ST_EX_Y2;
        ST_EX_Y2: begin
          hreg  <= prod[63:32];
          rreg  <= ONE_Q30;
          kcnt  <= 4'd13;
          state <= ST_EX_T;
        end
        ST_EX_T: state <= ST_EX_D;
        ST_EX_D: state <= ST_EX_R;
        ST_EX_R: begin
          rreg <= ONE_Q30 + quot;
          if (kcnt == 4'd1) begin
            state <= ST_EX_OUT;
          end else begin
            kcnt  <= kcnt - 4'd1;
            state <= ST_EX_T;
          end
        end
        ST_EX_OUT: begin
          if (ret_db) begin
            cur_gain <= exp_v;
            state    <= ST_EMIT;
          end else begin
            tg    <= exp_v;
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (cmd_r == CMD_JUMP || frames_r == 24'd0) begin
            cur_gain    <= tg;
            start_gain  <= tg;
            target_gain <= tg;
            ramp_len    <= 24'd0;
            ramp_pos    <= 24'd0;
            curve       <= CURVE_HOLD;
            state       <= ST_IDLE;
          end else begin
            start_gain  <= cur_gain;
            target_gain <= tg;
            ramp_len    <= frames_r;
            ramp_pos    <= 24'd0;
            lg_phase    <= 1'b0;
            if (cur_gain == 32'd0 && tg == 32'd0) begin
              curve <= CURVE_HOLD;
              state <= ST_IDLE;
            end else if (cur_gain == 32'd0) begin
              curve <= CURVE_IN;
              state <= ST_IDLE;
            end else if (tg == 32'd0) begin
              curve <= CURVE_OUT;
              state <= ST_IDLE;
            end else begin
              curve <= CURVE_DB;
              state <= ST_LG_INIT;
            end
          end
        end
        ST_LG_INIT: begin
          // normalize the mantissa into [1,2) in Q30
          lg_b    <= msb;
          lg_m    <= (msb == 5'd31) ? (lg_x >> 1) : (lg_x << (5'd30 - msb));
          lg_frac <= 32'd0;
          icnt    <= 5'd0;
          state   <= ST_LG_SQ;
        end
        ST_LG_SQ: state <= ST_LG_UP;
        ST_LG_UP: begin
          lg_frac <= {lg_frac[30:0], mm[31]};
          lg_m    <= mm[31] ? (mm >> 1) : mm;
          icnt    <= icnt + 5'd1;
          if (icnt == 5'd31) begin
            if (!lg_phase) begin
              log_start <= {lg_hi, lg_frac[30:0], mm[31]};
              lg_phase  <= 1'b1;
              state     <= ST_LG_INIT;
            end else begin
              log_diff <= {lg_hi, lg_frac[30:0], mm[31]} - log_start;
              state    <= ST_IDLE;
            end
          end else begin
            state <= ST_LG_SQ;
          end
        end
        ST_TK_START: begin
          if (ramp_pos >= ramp_len) begin
            state <= ST_EMIT;
          end else begin
            ramp_pos <= pos_inc;
            if (pos_inc == ramp_len) begin
              cur_gain <= target_gain;
              state    <= ST_EMIT;
            end else begin
              div_rem <= pos_inc;
              div_q   <= 24'd0;
              div_cnt <= 5'd0;
              state   <= ST_TK_DIV;
            end
          end
        end
        ST_TK_DIV: begin
          if (rem2 >= {1'b0, ramp_len}) begin
            div_rem <= 24'(rem2 - {1'b0, ramp_len});
            div_q   <= {div_q[22:0], 1'b1};
          end else begin
            div_rem <= rem2[23:0];
            div_q   <= {div_q[22:0], 1'b0};
          end
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd23) begin
            state <= ST_TK_SEL;
          end
        end
        ST_TK_SEL: begin
          prog <= div_q;
          case (curve)
            CURVE_IN: begin
              sarg  <= {1'b0, div_q};
              state <= ST_SN_X;
            end
            CURVE_OUT: begin
              sarg  <= 25'h100_0000 - {1'b0, div_q};
              state <= ST_SN_X;
            end
            CURVE_DB: state <= ST_DB_LO;
            default: begin
              cur_gain <= target_gain;
              state    <= ST_EMIT;
            end
          endcase
        end
        ST_SN_X: state <= ST_SN_X2;
        ST_SN_X2: begin
          xreg  <= {1'b0, prod[54:24]};
          state <= ST_SN_R0;
        end
        ST_SN_R0: begin
          hreg  <= prod[61:30];
          rreg  <= ONE_Q30;
          kcnt  <= 4'd8;
          state <= ST_SN_T;
        end
        ST_SN_T: state <= ST_SN_D;
        ST_SN_D: state <= ST_SN_R;
        ST_SN_R: begin
          rreg <= ONE_Q30 - quot;
          if (kcnt == 4'd1) begin
            state <= ST_SN_S;
          end else begin
            kcnt  <= kcnt - 4'd1;
            state <= ST_SN_T;
          end
        end
        ST_SN_S: state <= ST_SN_F;
        ST_SN_F: state <= ST_SN_G;
        ST_SN_G: begin
          cur_gain <= prod[61:30];
          state    <= ST_EMIT;
        end
        ST_DB_LO: state <= ST_DB_HI;
        ST_DB_HI: begin
          dlo   <= prod[55:24];
          state <= ST_DB_E;
        end
        ST_DB_E: begin
          // step along the log2 line toward the target
          e_reg  <= log_diff[39] ? (log_start - delta) : (log_start + delta);
          ret_db <= 1'b1;
          state  <= ST_EX_Y;
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_gain      <= cur_gain;
            out_ramping   <= (ramp_pos < ramp_len);
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {7'b0, out_ramping, out_gain};

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    ramp_pos <= ramp_len)
    else $error("ramp position past ramp length");

  a_lands_on_target: assert property (@(posedge clk) disable iff (rst)
    (ramp_len != 24'd0 && ramp_pos == ramp_len) |-> cur_gain == target_gain)
    else $error("finished ramp not on target");

  a_hold_only_silent: assert property (@(posedge clk) disable iff (rst)
    (ramp_pos < ramp_len && curve == CURVE_HOLD) |-> (start_gain == 32'd0 &&
    target_gain == 32'd0))
    else $error("hold curve on an audible ramp");

  a_series_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EX_T || state == ST_SN_T) |-> kcnt != 4'd0)
    else $error("series index out of range");

  a_emit_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_EMIT))
    else $error("result raised outside emit");

endmodule

`default_nettype wire
